[rtl/spht_pkg.sv]
// Shared types and constants for the spectrum peak history tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package spht_pkg;

   localparam int BIN_W      = 7;
   localparam int BINS       = 2 ** BIN_W;
   localparam int HIST_DEPTH = 128;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int LEVEL_W    = 8;
   localparam int DSQ_W      = 2 * BIN_W;
   localparam int PROD_W     = 32;
   localparam int CNT_W      = 9;
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [7:0]       DECAY_INTERVAL_RST = 8'd10;
   localparam logic [BIN_W-1:0] CURVE_CENTER_RST   = 7'd64;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HISTORY_MODE   = 3'd0,
      CSR_DECAY_INTERVAL = 3'd1,
      CSR_CURVE_WIDTH    = 3'd2,
      CSR_CURVE_CENTER   = 3'd3,
      CSR_CURVE_OFFSET   = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic               operation;
      logic [BIN_W-1:0]   bin_index;
      logic [LEVEL_W-1:0] level;
   } req_type;

   typedef struct packed {
      logic               above_threshold;
      logic [LEVEL_W-1:0] bin_level;
      logic [LEVEL_W-1:0] history_value;
   } rsp_type;

   typedef struct packed {
      logic               history_mode;
      logic [7:0]         decay_interval;
      logic signed [15:0] curve_width;
      logic [BIN_W-1:0]   curve_center;
      logic signed [15:0] curve_offset;
   } cfg_type;

   // classified item as it sits in the queue
   typedef struct packed {
      logic               is_sample;
      logic [BIN_W-1:0]   bin_index;
      logic [LEVEL_W-1:0] level;
      logic [DSQ_W-1:0]   dist_sq;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic busy;
      logic rsp_load;
   } bk_stat_type;

endpackage

`default_nettype wire

[rtl/spht_front.sv]
// Front end: accepts items, classifies sample vs read, squares the bin distance.
// Depends on spht_pkg.
`default_nettype none

module spht_front import spht_pkg::*; (
   input  wire cfg_type     cfg,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   input  wire q_stat_type  q_stat,
   output logic             q_push,
   output q_entry_type      q_entry
);

   logic [BIN_W:0]   diff;
   logic [BIN_W-1:0] abs_diff;

   assign req_ready = !q_stat.full;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      diff     = {1'b0, req_data.bin_index} - {1'b0, cfg.curve_center};
      abs_diff = diff[BIN_W] ? BIN_W'(-diff) : diff[BIN_W-1:0];
      q_entry.is_sample = (req_data.operation == OP_SAMPLE);
      q_entry.bin_index = req_data.bin_index;
      q_entry.level     = req_data.level;
      q_entry.dist_sq   = DSQ_W'({{BIN_W{1'b0}}, abs_diff} * {{BIN_W{1'b0}}, abs_diff});
   end

endmodule

`default_nettype wire

[rtl/spht_queue.sv]
// Short FIFO between the front end and the back end.
// Depends on spht_pkg.
`default_nettype none

module spht_queue import spht_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire q_entry_type push_data,
   input  wire logic        pop,
   output logic             q_valid,
   output q_entry_type      q_data,
   output q_stat_type       stat
);

   q_entry_type        entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign q_valid    = (count_ff != '0);
   assign q_data     = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == (Q_PTR_W + 1)'(Q_DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

`default_nettype wire

[rtl/spht_back.sv]
// Back end: threshold compare, level store, history update and result register.
// Depends on spht_pkg.
`default_nettype none

module spht_back import spht_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        q_valid,
   input  wire q_entry_type q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   output bk_stat_type      stat
);

   typedef enum logic {
      S_IDLE,
      S_UPD
   } state_type;

   state_type               state_ff, state_in;
   q_entry_type             cur_ff, cur_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [LEVEL_W-1:0]      hb_ff, hb_in;
   logic [LEVEL_W-1:0]      hbm1_ff, hbm1_in;
   logic                    lvl_ok_ff, lvl_ok_in;
   logic [LEVEL_W-1:0]      lvl_rd_ff;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [LEVEL_W-1:0]      hist_ff [HIST_DEPTH];
   logic [LEVEL_W-1:0]      hist_in [HIST_DEPTH];
   logic [BINS-1:0]         lvl_vld_ff, lvl_vld_in;
   logic [LEVEL_W-1:0]      lvl_mem [BINS];

   logic                    done;
   logic                    upd;
   logic signed [PROD_W-1:0] num;
   logic                    hit;
   logic [CNT_W-1:0]        cnt_inc;
   logic                    decay;
   logic [LEVEL_W-1:0]      push_val;
   logic [LEVEL_W-1:0]      hist_val;
   logic [HIST_AW-1:0]      cur_slot;

   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign done  = (state_ff == S_UPD) && (!rsp_valid_ff || rsp_ready);
   assign upd   = done && cur_ff.is_sample;

   // threshold = trunc((width*d^2 + offset*256) / 256); exceeded only if >= 0
   always_comb begin
      num = prod_ff + {{8{cfg.curve_offset[15]}}, cfg.curve_offset, 8'b0};
      hit = 1'b0;
      if (cur_ff.is_sample) begin
         if (!num[PROD_W-1]) begin
            hit = {{(PROD_W - 8 - LEVEL_W){1'b0}}, cur_ff.level} > num[PROD_W-1:8];
         end else if ((&num[PROD_W-1:8]) && (|num[7:0])) begin
            // small negative numerator truncates to zero
            hit = (cur_ff.level != '0);
         end
      end
      cnt_inc  = cnt_ff + 1'b1;
      decay    = !cfg.history_mode && (cnt_inc > {1'b0, cfg.decay_interval});
      push_val = {{(LEVEL_W - BIN_W){1'b0}}, cur_ff.bin_index};
      cur_slot = HIST_AW'(cur_ff.bin_index);
   end

   always_comb begin
      hist_val = hb_ff;
      if (cur_ff.is_sample) begin
         if (!cfg.history_mode) begin
            if (hit) begin
               hist_val = cur_ff.level;
            end else if (decay && hb_ff != '0) begin
               hist_val = hb_ff - 1'b1;
            end
         end else if (hit) begin
            hist_val = (cur_ff.bin_index == '0) ? push_val : hbm1_ff;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
         hist_in[i] = hist_ff[i];
         if (upd && !cfg.history_mode) begin
            if (decay && hist_ff[i] != '0) begin
               hist_in[i] = hist_ff[i] - 1'b1;
            end
            if (hit && cur_slot == HIST_AW'(i)) begin
               hist_in[i] = cur_ff.level;
            end
         end
      end
      if (upd && cfg.history_mode && hit) begin
         for (int i = 1; i < HIST_DEPTH; i++) begin
            hist_in[i] = hist_ff[i - 1];
         end
         hist_in[0] = push_val;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (upd) begin
         cnt_in = (cfg.history_mode || decay) ? '0 : cnt_inc;
      end
      lvl_vld_in = lvl_vld_ff;
      if (upd) begin
         lvl_vld_in[cur_ff.bin_index] = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      prod_in      = prod_ff;
      hb_in        = hb_ff;
      hbm1_in      = hbm1_ff;
      lvl_ok_in    = lvl_ok_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               cur_in    = q_data;
               prod_in   = $signed({{(PROD_W - 16){cfg.curve_width[15]}}, cfg.curve_width})
                         * $signed({{(PROD_W - DSQ_W){1'b0}}, q_data.dist_sq});
               hb_in     = hist_ff[HIST_AW'(q_data.bin_index)];
               hbm1_in   = hist_ff[HIST_AW'(q_data.bin_index) - 1'b1];
               lvl_ok_in = lvl_vld_ff[q_data.bin_index];
               state_in  = S_UPD;
            end
         end
         S_UPD: begin
            if (done) begin
               rsp_in.above_threshold = hit;
               rsp_in.bin_level       = cur_ff.is_sample ? cur_ff.level :
                                        (lvl_ok_ff ? lvl_rd_ff : '0);
               rsp_in.history_value   = hist_val;
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff    <= cur_in;
      prod_ff   <= prod_in;
      hb_ff     <= hb_in;
      hbm1_ff   <= hbm1_in;
      lvl_ok_ff <= lvl_ok_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         lvl_vld_ff <= '0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= LEVEL_W'(HIST_DEPTH - i);
         end
      end else begin
         cnt_ff     <= cnt_in;
         lvl_vld_ff <= lvl_vld_in;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   // level store; entries not yet written read as zero through the valid bits
   always_ff @(posedge clock) begin
      if (upd) begin
         lvl_mem[cur_ff.bin_index] <= cur_ff.level;
      end
      if (q_pop) begin
         lvl_rd_ff <= lvl_mem[q_data.bin_index];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;
   assign stat.busy     = (state_ff == S_UPD);
   assign stat.rsp_load = done;

endmodule

`default_nettype wire

[rtl/spectrum_peak_history_tracker_top.sv]
// Top level of the spectrum peak history tracker: control registers and wiring.
// Depends on spht_pkg, spht_front, spht_queue and spht_back.
`default_nettype none

// Each item (sample or read) passes the combinational front end, waits in a
// two-entry queue, and goes through the back-end states S_IDLE, which pops it
// and registers the curvature multiply and the level-store read, and S_UPD,
// for the compare, the history update and the result load; S_UPD waits while
// an earlier result is not yet taken. The back end finishes one item before
// it pops the next. Decay and stack shift act on all 128 history entries at
// once. Control registers are written through the csr_ port, never stalled;
// the user must write them only while the block is idle (not enforced here).
module spectrum_peak_history_tracker_top import spht_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   q_stat_type  q_stat;
   bk_stat_type bk_stat;
   logic        q_push;
   q_entry_type q_entry;
   logic        q_pop;
   logic        q_valid;
   q_entry_type q_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HISTORY_MODE:   cfg_in.history_mode   = csr_wdata[0];
            CSR_DECAY_INTERVAL: cfg_in.decay_interval = csr_wdata[7:0];
            CSR_CURVE_WIDTH:    cfg_in.curve_width    = $signed(csr_wdata);
            CSR_CURVE_CENTER:   cfg_in.curve_center   = csr_wdata[BIN_W-1:0];
            CSR_CURVE_OFFSET:   cfg_in.curve_offset   = $signed(csr_wdata);
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.history_mode   <= 1'b0;
         cfg_ff.decay_interval <= DECAY_INTERVAL_RST;
         cfg_ff.curve_width    <= '0;
         cfg_ff.curve_center   <= CURVE_CENTER_RST;
         cfg_ff.curve_offset   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   spht_front u_front (
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   spht_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .stat      (q_stat)
   );

   spht_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .stat      (bk_stat)
   );

`ifndef NO_ASSERTIONS
   a_queue_consistent : assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue reports full and empty together");

   a_rsp_from_update : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(bk_stat.busy) && $past(bk_stat.rsp_load))
      else $error("result appeared without a back-end update");

   a_accept_queued : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !q_stat.empty)
      else $error("accepted item did not reach the queue");

   a_pop_when_idle : assert property (@(posedge clock) disable iff (reset)
      q_pop |=> bk_stat.busy)
      else $error("back end did not start on a popped item");
`endif

endmodule

`default_nettype wire

[tb/sv/spectrum_peak_history_tracker_top_test.sv]
// Self-checking testbench for spectrum_peak_history_tracker_top: directed and random
// items, control register phases, and a scoreboard class that predicts every result.
// Depends on spht_pkg and the RTL of the block.

module spectrum_peak_history_tracker_top_test import spht_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // Tracks bin levels, peak history, decay count and settings; predicts each result.
   class peak_tracker_scoreboard;
      logic [LEVEL_W-1:0] levels [BINS];
      logic [LEVEL_W-1:0] history [HIST_DEPTH];
      logic [CNT_W-1:0]   decay_count;
      bit                 stack_mode;
      logic [7:0]         interval;
      shortint            width_q88;
      logic [BIN_W-1:0]   center;
      shortint            offset;
      rsp_type            expected_rsp_q [$];
      int                 failures;
      int                 results_seen;

      function new();
         foreach (levels[i]) levels[i] = '0;
         foreach (history[i]) history[i] = 8'(HIST_DEPTH - i);
         decay_count  = '0;
         stack_mode   = 1'b0;
         interval     = DECAY_INTERVAL_RST;
         width_q88    = 0;
         center       = CURVE_CENTER_RST;
         offset       = 0;
         failures     = 0;
         results_seen = 0;
      endfunction

      function void apply_reg(csr_idx_type idx, logic [15:0] value);
         case (idx)
            CSR_HISTORY_MODE:   stack_mode = value[0];
            CSR_DECAY_INTERVAL: interval = value[7:0];
            CSR_CURVE_WIDTH:    width_q88 = value;
            CSR_CURVE_CENTER:   center = value[BIN_W-1:0];
            CSR_CURVE_OFFSET:   offset = value;
            default: ;
         endcase
      endfunction

      // parabola threshold, Q8.8 product truncated toward zero; negative never exceeded
      function bit exceeds(int bin, int lvl);
         longint bin_delta;
         longint num;
         longint thr;
         bin_delta = longint'(bin) - longint'(center);
         num  = longint'(width_q88) * bin_delta * bin_delta + longint'(offset) * 256;
         thr  = num / 256;
         if (thr < 0) return 1'b0;
         return longint'(lvl) > thr;
      endfunction

      function void predict_response(req_type item);
         rsp_type exp_rsp;
         int      b;
         bit      hit;
         b   = item.bin_index;
         hit = 1'b0;
         if (item.operation == OP_SAMPLE) begin
            hit = exceeds(b, item.level);
            levels[b] = item.level;
            decay_count = decay_count + 1'b1;
            if (!stack_mode) begin
               if (decay_count > interval) begin
                  decay_count = '0;
                  foreach (history[i])
                     if (history[i] != 0) history[i] = history[i] - 1'b1;
               end
               if (hit) history[b] = item.level;
            end else begin
               if (hit) begin
                  for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
                  history[0] = 8'(b);
               end
               decay_count = '0;
            end
         end
         exp_rsp.above_threshold = hit;
         exp_rsp.bin_level       = levels[b];
         exp_rsp.history_value   = history[b];
         expected_rsp_q.push_back(exp_rsp);
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp_rsp;
         results_seen++;
         if (expected_rsp_q.size() == 0) begin
            if (failures < 10)
               $display("result %0d unexpected: above=%0b level=%0d hist=%0d",
                        results_seen, got.above_threshold, got.bin_level, got.history_value);
            failures++;
            return;
         end
         exp_rsp = expected_rsp_q.pop_front();
         if (got.above_threshold !== exp_rsp.above_threshold ||
             got.bin_level !== exp_rsp.bin_level ||
             got.history_value !== exp_rsp.history_value) begin
            if (failures < 10)
               $display("result %0d: exp above=%0b level=%0d hist=%0d got %0b %0d %0d",
                        results_seen, exp_rsp.above_threshold, exp_rsp.bin_level,
                        exp_rsp.history_value, got.above_threshold, got.bin_level,
                        got.history_value);
            failures++;
         end
      endfunction

      function int pending();
         return expected_rsp_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   peak_tracker_scoreboard sb;
   int tx_gap = 0;
   bit tx_burst = 1'b0;
   bit rx_burst = 1'b0;

   spectrum_peak_history_tracker_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int draw_gap(bit burst);
      return burst ? 0 : int'($urandom_range(0, 10));
   endfunction

   function automatic req_type mk(op_type op, int bin, int lvl);
      req_type r;
      r.operation = op;
      r.bin_index = BIN_W'(bin);
      r.level     = LEVEL_W'(lvl);
      return r;
   endfunction

   function automatic logic [15:0] pick_signed(int lo, int span);
      int v;
      case ($urandom_range(0, 7))
         0: v = 32767;
         1: v = -32768;
         2: v = int'($urandom_range(0, 65535));
         default: v = int'($urandom_range(0, span)) + lo;
      endcase
      return v[15:0];
   endfunction

   // valid stays high into the next item only when that item follows with no gap
   task automatic send_item(input req_type item, input bit more);
      repeat (tx_gap) @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      sb.predict_response(item);
      tx_gap = draw_gap(tx_burst);
      if (!more || tx_gap > 0) req_valid <= 1'b0;
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [15:0] value, input bit more);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      sb.apply_reg(idx, value);
      if (!more) csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin : result_side
      int stall;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = draw_gap(rx_burst);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         sb.check_response(rsp_data);
      end
   end

   initial begin : stimulus
      req_type item;
      bit      more;
      int      sel;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: threshold is zero on every bin
      send_item(mk(OP_READ, 0, 0), 1'b1);
      send_item(mk(OP_READ, 127, 0), 1'b1);
      send_item(mk(OP_READ, 64, 255), 1'b1);
      send_item(mk(OP_SAMPLE, 0, 0), 1'b1);
      send_item(mk(OP_SAMPLE, 127, 255), 1'b1);
      send_item(mk(OP_SAMPLE, 64, 1), 1'b1);
      // eleventh sample crosses the interval and decays the history
      repeat (8) send_item(mk(OP_SAMPLE, 5, 0), 1'b1);
      send_item(mk(OP_READ, 127, 0), 1'b1);
      send_item(mk(OP_READ, 0, 0), 1'b0);
      wait_drained();

      // stack mode, extreme curve: vertex threshold at max, far bins negative
      write_csr(CSR_HISTORY_MODE, 16'd1, 1'b1);
      write_csr(CSR_DECAY_INTERVAL, 16'd0, 1'b1);
      write_csr(CSR_CURVE_WIDTH, 16'h8000, 1'b1);
      write_csr(CSR_CURVE_CENTER, 16'd127, 1'b1);
      write_csr(CSR_CURVE_OFFSET, 16'h7fff, 1'b0);
      send_item(mk(OP_SAMPLE, 127, 255), 1'b1);
      send_item(mk(OP_SAMPLE, 0, 255), 1'b1);
      send_item(mk(OP_READ, 0, 0), 1'b0);
      wait_drained();

      // flat zero threshold: pushes onto the stack
      write_csr(CSR_CURVE_WIDTH, 16'd0, 1'b1);
      write_csr(CSR_CURVE_CENTER, 16'd0, 1'b1);
      write_csr(CSR_CURVE_OFFSET, 16'd0, 1'b0);
      send_item(mk(OP_SAMPLE, 100, 200), 1'b1);
      send_item(mk(OP_SAMPLE, 3, 1), 1'b1);
      send_item(mk(OP_SAMPLE, 7, 0), 1'b1);
      send_item(mk(OP_READ, 0, 0), 1'b1);
      send_item(mk(OP_READ, 1, 0), 1'b0);

      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         write_csr(CSR_HISTORY_MODE, 16'($urandom_range(0, 1)), 1'b1);
         sel = $urandom_range(0, 5);
         write_csr(CSR_DECAY_INTERVAL,
                   sel == 0 ? 16'd0 : sel == 1 ? 16'd255 : 16'($urandom_range(0, 20)), 1'b1);
         write_csr(CSR_CURVE_WIDTH, pick_signed(-32, 64), 1'b1);
         sel = $urandom_range(0, 7);
         write_csr(CSR_CURVE_CENTER,
                   sel == 0 ? 16'd0 : sel == 1 ? 16'd127 : 16'($urandom_range(0, 127)), 1'b1);
         write_csr(CSR_CURVE_OFFSET, pick_signed(-40, 300), 1'b0);
         tx_burst = ($urandom_range(0, 3) == 0);
         rx_burst = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < 75; n++) begin
            item.operation = ($urandom_range(0, 6) == 0) ? OP_READ : OP_SAMPLE;
            item.bin_index = BIN_W'($urandom_range(0, BINS - 1));
            item.level     = LEVEL_W'($urandom_range(0, 255));
            more = (n != 74) && ($urandom_range(0, 39) != 0);
            send_item(item, more);
            // occasional hold until the block has answered everything
            if (!more) wait_drained();
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
